/* sv/fan_hysteresis_controller_assert.svh */
// ---------------------------------------------------------------------------
// Fan hysteresis controller assertion macros
// Clocked, reset-qualified assertion wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef FAN_HYSTERESIS_CONTROLLER_ASSERT_SVH
`define FAN_HYSTERESIS_CONTROLLER_ASSERT_SVH

// assert a property on the rising clock, off while in reset
`define FHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fan controller check failed");

// assert an implication on the rising clock, off while in reset
`define FHC_ASSERT_IMPL(label, ante, cons) \
  `FHC_ASSERT(label, (ante) |-> (cons))

`endif

/* sv/fhc_pkg.sv */
// ---------------------------------------------------------------------------
// Fan hysteresis controller package
// Payload, configuration and state types, register indexes and reset values.
// ---------------------------------------------------------------------------
package fhc_pkg;

  typedef struct packed {
    logic       tick;
    logic       button_pressed;
    logic [7:0] temp_sample;
  } in_t;

  typedef struct packed {
    logic       fan_on;
    logic       is_hot;
    logic [1:0] override_mode;
    logic       sample_taken;
  } out_t;

  typedef struct packed {
    logic [7:0] hot_threshold;
    logic [7:0] cool_threshold;
    logic [7:0] cool_down_ticks;
    logic [7:0] measure_interval;
  } cfg_t;

  typedef enum logic [2:0] {
    OVR_NONE = 3'b001,
    OVR_ON   = 3'b010,
    OVR_OFF  = 3'b100
  } ovr_e;

  typedef struct packed {
    logic [7:0] time_count;
    logic [7:0] last_measure_time;
    logic [7:0] last_hot_time;
    logic       hot_flag;
    logic       button_held;
    ovr_e       override_state;
    logic       fan_state;
  } state_t;

  localparam logic [1:0] REG_HOT_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_COOL_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_COOL_DOWN_TICKS  = 2'd2;
  localparam logic [1:0] REG_MEASURE_INTERVAL = 2'd3;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;

  localparam cfg_t CFG_RESET = '{
    hot_threshold:    8'd23,
    cool_threshold:   8'd27,
    cool_down_ticks:  8'd125,
    measure_interval: 8'd32
  };

  localparam state_t STATE_RESET = '{
    time_count:        8'd0,
    last_measure_time: 8'd0,
    last_hot_time:     8'd162,
    hot_flag:          1'b0,
    button_held:       1'b0,
    override_state:    OVR_NONE,
    fan_state:         1'b0
  };

endpackage

/* sv/fan_hysteresis_controller.sv */
// A transaction is captured in the input register, its result in the result register.
// Throughput: one transaction per cycle unless the output stalls; the core is a
//   single short compare and add pass between the input and result registers.
// The input takes a new transaction while a result waits, as long as the
//   input register empties into the result register in that cycle.
// Reset: asynchronous, clears valids, loads loop state and configuration defaults.
// ---------------------------------------------------------------------------
// Fan hysteresis controller
// Fan drive with thermal hysteresis, cool-down timer and button override.
// ---------------------------------------------------------------------------
module fan_hysteresis_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fhc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fhc_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i
);
  import fhc_pkg::*;

  logic   in_valid_q;
  in_t    in_data_q;
  logic   out_valid_q;
  out_t   out_data_q;
  state_t state_q;
  state_t state_d;
  out_t   result_d;
  cfg_t   cfg_q;
  logic   advance;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  fhc_core u_core (
    .state_i  (state_q),
    .item_i   (in_data_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
      cfg_q       <= CFG_RESET;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HOT_THRESHOLD:    cfg_q.hot_threshold    <= cfg_wdata_i;
          REG_COOL_THRESHOLD:   cfg_q.cool_threshold   <= cfg_wdata_i;
          REG_COOL_DOWN_TICKS:  cfg_q.cool_down_ticks  <= cfg_wdata_i;
          REG_MEASURE_INTERVAL: cfg_q.measure_interval <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* sv/fhc_core.sv */
// ---------------------------------------------------------------------------
// Fan hysteresis controller core
// One control-loop pass: time count, sampling with hysteresis, button
// override and fan decision, as next state and result.
// ---------------------------------------------------------------------------
module fhc_core (
  input  fhc_pkg::state_t state_i,
  input  fhc_pkg::in_t    item_i,
  input  fhc_pkg::cfg_t   cfg_i,
  output fhc_pkg::state_t state_o,
  output fhc_pkg::out_t   result_o
);
  import fhc_pkg::*;

  logic [7:0] time_nxt;
  logic [7:0] since_measure;
  logic [7:0] since_hot;
  logic [7:0] cool_start;
  logic       took;
  logic       hot_nxt;
  logic       press;
  logic [7:0] hot_time_a;
  logic [7:0] hot_time_b;
  ovr_e       ovr_nxt;
  logic       fan_a;
  logic       run_fan;
  state_t     st;
  logic [1:0] mode;

  assign time_nxt      = state_i.time_count + {7'd0, item_i.tick};
  assign since_measure = time_nxt - state_i.last_measure_time;
  assign took          = since_measure >= cfg_i.measure_interval;
  assign cool_start    = time_nxt - cfg_i.cool_down_ticks;
  assign press         = item_i.button_pressed & ~state_i.button_held;

  always_comb begin
    hot_nxt = state_i.hot_flag;
    if (took) begin
      if (item_i.temp_sample > cfg_i.cool_threshold) begin
        hot_nxt = 1'b0;
      end else if (item_i.temp_sample < cfg_i.hot_threshold) begin
        hot_nxt = 1'b1;
      end
    end
  end

  assign hot_time_a = (took && hot_nxt) ? time_nxt : state_i.last_hot_time;

  always_comb begin
    ovr_nxt    = state_i.override_state;
    fan_a      = state_i.fan_state;
    hot_time_b = hot_time_a;
    if (press) begin
      case (state_i.override_state)
        OVR_NONE: begin
          ovr_nxt = OVR_ON;
          fan_a   = 1'b1;
        end
        OVR_ON: begin
          ovr_nxt = OVR_OFF;
          fan_a   = 1'b0;
        end
        default: begin
          ovr_nxt = OVR_NONE;
          if (!hot_nxt) begin
            hot_time_b = cool_start;
          end
        end
      endcase
    end
  end

  assign since_hot = time_nxt - hot_time_b;
  assign run_fan   = hot_nxt || (since_hot < cfg_i.cool_down_ticks);

  always_comb begin
    st.time_count        = time_nxt;
    st.last_measure_time = took ? time_nxt : state_i.last_measure_time;
    st.last_hot_time     = hot_time_b;
    st.hot_flag          = hot_nxt;
    st.button_held       = item_i.button_pressed;
    st.override_state    = ovr_nxt;
    st.fan_state         = fan_a;
    if (ovr_nxt == OVR_NONE) begin
      st.fan_state = run_fan;
      if (!run_fan) begin
        st.last_hot_time = cool_start;
      end
    end
  end

  always_comb begin
    case (ovr_nxt)
      OVR_NONE: mode = MODE_NONE;
      OVR_ON:   mode = MODE_ON;
      OVR_OFF:  mode = MODE_OFF;
      default:  mode = MODE_NONE;
    endcase
  end

  assign state_o                = st;
  assign result_o.fan_on        = st.fan_state;
  assign result_o.is_hot        = hot_nxt;
  assign result_o.override_mode = mode;
  assign result_o.sample_taken  = took;

endmodule

/* sv/fhc_checker.sv */
// ---------------------------------------------------------------------------
// Fan hysteresis controller checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "fan_hysteresis_controller_assert.svh"

module fhc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input fhc_pkg::out_t out_data_o
);
  import fhc_pkg::*;

  logic shown;
  logic mode_none;
  logic mode_on;
  logic mode_off;

  assign shown     = out_valid_o;
  assign mode_none = out_data_o.override_mode == MODE_NONE;
  assign mode_on   = out_data_o.override_mode == MODE_ON;
  assign mode_off  = out_data_o.override_mode == MODE_OFF;

  `FHC_ASSERT(a_out_hold, shown && !out_ready_i |=> shown && $stable(out_data_o))
  `FHC_ASSERT_IMPL(a_mode_legal, shown, mode_none || mode_on || mode_off)
  `FHC_ASSERT_IMPL(a_forced_off, shown && mode_off, !out_data_o.fan_on)
  `FHC_ASSERT_IMPL(a_forced_on, shown && mode_on, out_data_o.fan_on)
  `FHC_ASSERT_IMPL(a_hot_runs, shown && mode_none && out_data_o.is_hot, out_data_o.fan_on)

endmodule

bind fan_hysteresis_controller fhc_checker u_fhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// Fan hysteresis controller testbench
// Drives loop-pass transactions through the controller under random idling on
// both channels, predicts fan, hot flag, override mode and sample use for each
// pass, and compares every result field by field in order.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fhc_pkg::*;

  localparam int unsigned CLK_PERIOD      = 4;
  localparam int unsigned IDLE_LIMIT      = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned RANDOM_PHASES   = 8;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_t        in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = REG_HOT_THRESHOLD;
  logic [7:0] cfg_wdata_i = '0;

  fan_hysteresis_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Controller mirror
  cfg_t       fan_cfg;
  logic [7:0] now_ticks;
  logic [7:0] last_sample_ticks;
  logic [7:0] last_hot_ticks;
  logic       running_hot;
  logic       button_down;
  logic [1:0] mode;
  logic       fan_drive;

  out_t        pending_fan_results[$];
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  bit          send_no_idle = 1'b0;
  bit          recv_no_idle = 1'b0;
  logic        button_level = 1'b0;

  function automatic out_t fan_loop_pass(in_t pass);
    out_t       res;
    logic       took;
    logic [7:0] elapsed;
    took = 1'b0;
    if (pass.tick) begin
      now_ticks = now_ticks + 8'd1;
    end
    elapsed = now_ticks - last_sample_ticks;
    if (elapsed >= fan_cfg.measure_interval) begin
      took = 1'b1;
      last_sample_ticks = now_ticks;
      if (pass.temp_sample > fan_cfg.cool_threshold) begin
        running_hot = 1'b0;
      end else if (pass.temp_sample < fan_cfg.hot_threshold) begin
        running_hot = 1'b1;
      end
      if (running_hot) begin
        last_hot_ticks = now_ticks;
      end
    end
    if (pass.button_pressed && !button_down) begin
      button_down = 1'b1;
      case (mode)
        MODE_NONE: begin
          mode      = MODE_ON;
          fan_drive = 1'b1;
        end
        MODE_ON: begin
          mode      = MODE_OFF;
          fan_drive = 1'b0;
        end
        default: begin
          mode = MODE_NONE;
          if (!running_hot) begin
            last_hot_ticks = now_ticks - fan_cfg.cool_down_ticks;
          end
        end
      endcase
    end else if (!pass.button_pressed && button_down) begin
      button_down = 1'b0;
    end
    if (mode == MODE_NONE) begin
      elapsed = now_ticks - last_hot_ticks;
      if (running_hot || elapsed < fan_cfg.cool_down_ticks) begin
        fan_drive = 1'b1;
      end else begin
        fan_drive      = 1'b0;
        last_hot_ticks = now_ticks - fan_cfg.cool_down_ticks;
      end
    end
    res.fan_on        = fan_drive;
    res.is_hot        = running_hot;
    res.override_mode = mode;
    res.sample_taken  = took;
    return res;
  endfunction

  function automatic int unsigned draw_wait(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_reading(input logic tick, input logic button, input logic [7:0] sample);
    int unsigned gap;
    in_t         pass;
    pass.tick           = tick;
    pass.button_pressed = button;
    pass.temp_sample    = sample;
    if ($urandom_range(0, 39) == 0) begin
      send_no_idle = !send_no_idle;
    end
    gap = draw_wait(send_no_idle);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pass;
    do @(posedge clk_i); while (!in_ready_o);
    pending_fan_results.push_back(fan_loop_pass(pass));
  endtask

  // Hold off until every result is back, then let the pipeline go quiet
  task automatic settle(input int unsigned extra);
    in_valid_i <= 1'b0;
    while (pending_fan_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_settings(input cfg_t c);
    settle(3);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_HOT_THRESHOLD;
    cfg_wdata_i <= c.hot_threshold;
    @(posedge clk_i);
    cfg_idx_i   <= REG_COOL_THRESHOLD;
    cfg_wdata_i <= c.cool_threshold;
    @(posedge clk_i);
    cfg_idx_i   <= REG_COOL_DOWN_TICKS;
    cfg_wdata_i <= c.cool_down_ticks;
    @(posedge clk_i);
    cfg_idx_i   <= REG_MEASURE_INTERVAL;
    cfg_wdata_i <= c.measure_interval;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fan_cfg   = c;
    @(posedge clk_i);
  endtask

  task automatic test_post_reset_run();
    send_reading(1'b0, 1'b0, 8'd0);
    send_reading(1'b0, 1'b0, 8'd255);
    send_reading(1'b1, 1'b0, 8'd0);
    send_reading(1'b1, 1'b0, 8'd128);
  endtask

  task automatic test_hysteresis_and_override();
    write_settings('{hot_threshold: 8'd23, cool_threshold: 8'd27,
                     cool_down_ticks: 8'd3, measure_interval: 8'd1});
    send_reading(1'b1, 1'b0, 8'd0);
    send_reading(1'b1, 1'b0, 8'd25);
    send_reading(1'b1, 1'b0, 8'd255);
    send_reading(1'b1, 1'b0, 8'd27);
    send_reading(1'b1, 1'b0, 8'd28);
    send_reading(1'b1, 1'b0, 8'd23);
    send_reading(1'b1, 1'b0, 8'd22);
    send_reading(1'b0, 1'b1, 8'd255);
    send_reading(1'b0, 1'b1, 8'd255);
    send_reading(1'b1, 1'b0, 8'd255);
    send_reading(1'b1, 1'b1, 8'd255);
    send_reading(1'b1, 1'b0, 8'd0);
    send_reading(1'b0, 1'b1, 8'd255);
    send_reading(1'b1, 1'b0, 8'd255);
  endtask

  task automatic test_zero_interval_and_cool_down();
    write_settings('{hot_threshold: 8'd23, cool_threshold: 8'd27,
                     cool_down_ticks: 8'd0, measure_interval: 8'd0});
    send_reading(1'b0, 1'b0, 8'd0);
    send_reading(1'b0, 1'b0, 8'd255);
    send_reading(1'b0, 1'b0, 8'd128);
  endtask

  task automatic test_threshold_overlap();
    write_settings('{hot_threshold: 8'd200, cool_threshold: 8'd100,
                     cool_down_ticks: 8'd1, measure_interval: 8'd1});
    send_reading(1'b1, 1'b0, 8'd150);
    send_reading(1'b1, 1'b0, 8'd50);
    send_reading(1'b1, 1'b0, 8'd150);
  endtask

  task automatic test_random_settings();
    cfg_t       c;
    logic [7:0] sample;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: c = '{hot_threshold: 8'd0, cool_threshold: 8'd0,
                 cool_down_ticks: 8'd1, measure_interval: 8'd1};
        1: c = '{hot_threshold: 8'd255, cool_threshold: 8'd255,
                 cool_down_ticks: 8'd255, measure_interval: 8'd255};
        2: c = CFG_RESET;
        default: begin
          c.hot_threshold  = 8'($urandom_range(0, 255));
          c.cool_threshold = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : c.hot_threshold + 8'($urandom_range(0, 16));
          c.cool_down_ticks  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                           : 8'($urandom_range(1, 40));
          c.measure_interval = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                           : 8'($urandom_range(1, 8));
        end
      endcase
      write_settings(c);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 5) == 0) begin
          button_level = !button_level;
        end
        case ($urandom_range(0, 2))
          0: sample = c.hot_threshold + 8'($urandom_range(0, 3)) - 8'd2;
          1: sample = c.cool_threshold + 8'($urandom_range(0, 3)) - 8'd1;
          default: sample = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 99) == 0) begin
          settle(0);
        end
        send_reading($urandom_range(0, 3) != 0, button_level, sample);
      end
    end
  endtask

  task automatic report_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  initial begin : result_checker
    int unsigned stall;
    out_t        want;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        recv_no_idle = !recv_no_idle;
      end
      stall = draw_wait(recv_no_idle);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_fan_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected transaction, expected none, actual %p", $time, out_data_o);
      end else begin
        want = pending_fan_results.pop_front();
        report_field("fan_on", want.fan_on, out_data_o.fan_on);
        report_field("is_hot", want.is_hot, out_data_o.is_hot);
        report_field("override_mode", want.override_mode, out_data_o.override_mode);
        report_field("sample_taken", want.sample_taken, out_data_o.sample_taken);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fan_cfg           = CFG_RESET;
    now_ticks         = STATE_RESET.time_count;
    last_sample_ticks = STATE_RESET.last_measure_time;
    last_hot_ticks    = STATE_RESET.last_hot_time;
    running_hot       = STATE_RESET.hot_flag;
    button_down       = STATE_RESET.button_held;
    mode              = MODE_NONE;
    fan_drive         = STATE_RESET.fan_state;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_post_reset_run();
    test_hysteresis_and_override();
    test_zero_interval_and_cool_down();
    test_threshold_overlap();
    test_random_settings();
    settle(10);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
